@@ design/intel_hex_record_encoder_assert.svh @@
// ---------------------------------------------------------------------------
// Intel HEX record encoder assertion macros
// Shared property forms, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_ENCODER_ASSERT_SVH
`define INTEL_HEX_RECORD_ENCODER_ASSERT_SVH

// Check a condition at every clock edge.
`define IHRE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequence in the cycle after the antecedent.
`define IHRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ihre_pkg.sv @@
// ---------------------------------------------------------------------------
// ihre_pkg
// Types, constants and helpers shared by the Intel HEX record encoder.
// ---------------------------------------------------------------------------
package ihre_pkg;

  localparam int          BYTES_PER_RECORD_DEF = 16;
  localparam logic [15:0] START_ADDRESS_RST    = 16'h0100;

  localparam logic [7:0]  TYPE_DATA = 8'h00;
  localparam logic [7:0]  TYPE_END  = 8'h01;

  localparam logic [6:0]  CHAR_COLON = 7'h3A;
  localparam logic [6:0]  CHAR_EOL   = 7'h0A;
  localparam logic [6:0]  CHAR_ZERO  = 7'h30;
  localparam logic [6:0]  CHAR_ALPHA = 7'h37;

  typedef enum logic [2:0] {
    FLD_COLON,
    FLD_COUNT,
    FLD_ADDR_HI,
    FLD_ADDR_LO,
    FLD_TYPE,
    FLD_DATA,
    FLD_CSUM,
    FLD_EOL
  } field_t;

  typedef struct packed {
    logic   store;
    logic   out_load;
    field_t field;
    logic   nib_lo;
    logic   out_last;
    logic   end_rec;
    logic   idx_inc;
    logic   rec_clear;
    logic   end_clear;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic fill_last;
    logic data_done;
  } sts_t;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    if (d > 4'd9) begin
      return CHAR_ALPHA + 7'(d);
    end
    return CHAR_ZERO + 7'(d);
  endfunction

endpackage

@@ design/ihre_dpath.sv @@
// ---------------------------------------------------------------------------
// ihre_dpath
// Record buffer, address and checksum state, and the character register.
// ---------------------------------------------------------------------------
module ihre_dpath #(
  parameter int BYTES_PER_RECORD = ihre_pkg::BYTES_PER_RECORD_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  input  logic [7:0]      in_byte,
  input  ihre_pkg::cmd_t  cmd,
  output ihre_pkg::sts_t  sts,
  output logic [6:0]      out_char,
  output logic            out_last
);
  import ihre_pkg::*;

  localparam int CNT_W = $clog2(BYTES_PER_RECORD + 1);
  localparam int IDX_W = (BYTES_PER_RECORD > 1) ? $clog2(BYTES_PER_RECORD) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BYTES_PER_RECORD - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [15:0]      start_address;
  logic [15:0]      record_address;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       data_sum;
  logic [IDX_W-1:0] idx;
  logic [7:0]       record_buffer [BYTES_PER_RECORD];

  logic [7:0]  count8;
  logic [15:0] addr;
  logic [7:0]  rec_type;
  logic [7:0]  dsum;
  logic [7:0]  csum;
  logic [7:0]  value;
  logic [3:0]  nibble;
  logic [6:0]  char_sel;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      record_buffer[byte_count[IDX_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address  <= START_ADDRESS_RST;
      record_address <= START_ADDRESS_RST;
      byte_count     <= '0;
      data_sum       <= '0;
      idx            <= '0;
    end else begin
      if (cfg_we) begin
        start_address <= cfg_wdata;
        if (byte_count == '0) begin
          record_address <= cfg_wdata;
        end
      end
      if (cmd.store) begin
        byte_count <= byte_count + CNT_ONE;
        data_sum   <= data_sum + in_byte;
      end
      if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.rec_clear) begin
        byte_count     <= '0;
        data_sum       <= '0;
        idx            <= '0;
        record_address <= record_address + 16'(byte_count);
      end
      if (cmd.end_clear) begin
        record_address <= start_address;
        idx            <= '0;
      end
    end
  end

  always_comb begin
    count8   = cmd.end_rec ? 8'h00 : 8'(byte_count);
    addr     = cmd.end_rec ? 16'h0000 : record_address;
    rec_type = cmd.end_rec ? TYPE_END : TYPE_DATA;
    dsum     = cmd.end_rec ? 8'h00 : data_sum;
    csum     = 8'h00 - (count8 + addr[15:8] + addr[7:0] + rec_type + dsum);
    case (cmd.field)
      FLD_COUNT:   value = count8;
      FLD_ADDR_HI: value = addr[15:8];
      FLD_ADDR_LO: value = addr[7:0];
      FLD_TYPE:    value = rec_type;
      FLD_DATA:    value = record_buffer[idx];
      FLD_CSUM:    value = csum;
      default:     value = 8'h00;
    endcase
    nibble = cmd.nib_lo ? value[3:0] : value[7:4];
    case (cmd.field)
      FLD_COLON: char_sel = CHAR_COLON;
      FLD_EOL:   char_sel = CHAR_EOL;
      default:   char_sel = hex_char(nibble);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char <= char_sel;
      out_last <= cmd.out_last;
    end
  end

  assign sts.count_zero = (byte_count == '0);
  assign sts.fill_last  = (byte_count == CNT_LAST);
  assign sts.data_done  = ((CNT_W'(idx) + CNT_ONE) == byte_count);

endmodule

@@ design/ihre_ctrl.sv @@
// ---------------------------------------------------------------------------
// ihre_ctrl
// Record sequencer: accepts requests and steps through the record fields.
// ---------------------------------------------------------------------------
`include "intel_hex_record_encoder_assert.svh"

module ihre_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic           s_op,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  ihre_pkg::sts_t sts,
  output ihre_pkg::cmd_t cmd
);
  import ihre_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_COLON   = 9'b000000010,
    S_COUNT   = 9'b000000100,
    S_ADDR_HI = 9'b000001000,
    S_ADDR_LO = 9'b000010000,
    S_TYPE    = 9'b000100000,
    S_DATA    = 9'b001000000,
    S_CSUM    = 9'b010000000,
    S_EOL     = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   nib, nib_next;
  logic   end_rec, end_rec_next;
  logic   end_pend, end_pend_next;
  logic   m_tvalid_next;
  logic   advance;
  logic   accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign advance  = (state != S_IDLE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next    = state;
    nib_next      = nib;
    end_rec_next  = end_rec;
    end_pend_next = end_pend;
    cmd           = '0;
    cmd.field     = FLD_COLON;
    cmd.nib_lo    = nib;
    cmd.end_rec   = end_rec;
    cmd.out_load  = advance;
    if (advance && state != S_COLON && state != S_EOL) begin
      nib_next = !nib;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!s_op) begin
            cmd.store = 1'b1;
            if (sts.fill_last) begin
              state_next = S_COLON;
            end
          end else begin
            if (sts.count_zero) begin
              end_rec_next = 1'b1;
            end else begin
              end_pend_next = 1'b1;
            end
            state_next = S_COLON;
          end
        end
      end
      S_COLON: begin
        cmd.field = FLD_COLON;
        if (advance) begin
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.field = FLD_COUNT;
        if (advance && nib) begin
          state_next = S_ADDR_HI;
        end
      end
      S_ADDR_HI: begin
        cmd.field = FLD_ADDR_HI;
        if (advance && nib) begin
          state_next = S_ADDR_LO;
        end
      end
      S_ADDR_LO: begin
        cmd.field = FLD_ADDR_LO;
        if (advance && nib) begin
          state_next = S_TYPE;
        end
      end
      S_TYPE: begin
        cmd.field = FLD_TYPE;
        if (advance && nib) begin
          state_next = end_rec ? S_CSUM : S_DATA;
        end
      end
      S_DATA: begin
        cmd.field = FLD_DATA;
        if (advance && nib) begin
          if (sts.data_done) begin
            state_next = S_CSUM;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_CSUM: begin
        cmd.field = FLD_CSUM;
        if (advance && nib) begin
          state_next = S_EOL;
        end
      end
      S_EOL: begin
        cmd.field    = FLD_EOL;
        cmd.out_last = !end_pend;
        if (advance) begin
          if (end_rec) begin
            cmd.end_clear = 1'b1;
            end_rec_next  = 1'b0;
            state_next    = S_IDLE;
          end else begin
            cmd.rec_clear = 1'b1;
            if (end_pend) begin
              end_pend_next = 1'b0;
              end_rec_next  = 1'b1;
              state_next    = S_COLON;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (advance) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      nib      <= 1'b0;
      end_rec  <= 1'b0;
      end_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      nib      <= nib_next;
      end_rec  <= end_rec_next;
      end_pend <= end_pend_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  `IHRE_ASSERT_ALWAYS(a_pend_excl, !(end_pend && end_rec), "flush pending during end record")
  `IHRE_ASSERT_ALWAYS(a_end_no_data, !(state == S_DATA && end_rec), "end record in data field")
  `IHRE_ASSERT_NEXT(a_last_idle, advance && cmd.out_last, state == S_IDLE, "last not at idle")

endmodule

@@ design/intel_hex_record_encoder.sv @@
// ---------------------------------------------------------------------------
// intel_hex_record_encoder
// Byte stream to Intel HEX text, one ASCII character per output request.
// ---------------------------------------------------------------------------
// A data byte is taken while the sequencer is idle. The byte that fills a
// record, and an end request, start the character sequencer, which emits one
// character per cycle while the output is not stalled and holds off input
// until the final newline is registered. An end request emits the partial
// record, if any, and then the end record. tlast marks the final character
// caused by each input request. start_address must be written only while the
// block is idle; the block itself does not enforce this. A write moves the
// current base only when no bytes are buffered.
module intel_hex_record_encoder #(
  parameter int BYTES_PER_RECORD = ihre_pkg::BYTES_PER_RECORD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,    // start_address
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] data_byte
  input  logic        s_tuser,      // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,      // [6:0] character, [7] zero
  output logic        m_tlast
);
  import ihre_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [6:0] out_char;

  ihre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_op     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ihre_dpath #(
    .BYTES_PER_RECORD (BYTES_PER_RECORD)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_byte   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the Intel HEX record encoder: a table of directed
// requests, then random byte streams with end requests and start address
// changes between phases, all scored character by character against an
// in-bench encoder model under random source gaps and sink stalls.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihre_pkg::*;

  localparam int          NUM_RECORD_BYTES = BYTES_PER_RECORD_DEF;
  localparam int          RANDOM_ITEMS     = 460;
  localparam int          LONG_HOLD_CYCLES = 300;
  localparam int          SETTLE_CYCLES    = 4;
  localparam logic        OP_DATA          = 1'b0;
  localparam logic        OP_END           = 1'b1;
  localparam logic [7:0]  END_COUNT        = 8'h00;
  localparam logic [15:0] END_ADDRESS      = 16'h0000;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       bare_end;
  } dir_row_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{OP_END,  8'h00, 1'b1},
    '{OP_END,  8'h00, 1'b1},
    '{OP_DATA, 8'h00, 1'b0}, '{OP_DATA, 8'hFF, 1'b0}, '{OP_DATA, 8'h01, 1'b0},
    '{OP_DATA, 8'hFE, 1'b0}, '{OP_DATA, 8'h80, 1'b0}, '{OP_DATA, 8'h7F, 1'b0},
    '{OP_DATA, 8'h0F, 1'b0}, '{OP_DATA, 8'hF0, 1'b0}, '{OP_DATA, 8'hAA, 1'b0},
    '{OP_DATA, 8'h55, 1'b0}, '{OP_DATA, 8'h09, 1'b0}, '{OP_DATA, 8'h0A, 1'b0},
    '{OP_DATA, 8'h90, 1'b0}, '{OP_DATA, 8'hA0, 1'b0}, '{OP_DATA, 8'h99, 1'b0},
    '{OP_DATA, 8'hFA, 1'b0},
    '{OP_DATA, 8'hFF, 1'b0}, '{OP_DATA, 8'h00, 1'b0}, '{OP_DATA, 8'h3C, 1'b0},
    '{OP_END,  8'hFF, 1'b0},
    '{OP_END,  8'h00, 1'b1}
  };

  localparam int NUM_SWEEP = 5;
  localparam logic [15:0] START_SWEEP [NUM_SWEEP] = '{
    16'hFFF8, 16'h0000, 16'hFFFF, START_ADDRESS_RST, 16'hFFF0
  };

  localparam string END_RECORD_TEXT = ":00000001FF\n";

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  text_char_t  expected_text [$];
  int          err_count;
  int          burst_left;
  bit          long_hold;

  logic [15:0] mdl_start;
  logic [7:0]  mdl_buf [NUM_RECORD_BYTES];
  logic [4:0]  mdl_count;
  logic [15:0] mdl_next;
  logic [15:0] mdl_rec_addr;
  logic [7:0]  mdl_sum;

  intel_hex_record_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [6:0] nibble_ascii(input logic [3:0] d);
    if (d > 4'd9) begin
      return 7'("A" - 8'd10 + 8'(d));
    end
    return 7'("0" + 8'(d));
  endfunction

  function automatic void put_text_char(input logic [6:0] ch);
    expected_text.push_back('{ch: ch, last: 1'b0});
  endfunction

  function automatic void put_hex_byte(input logic [7:0] v);
    put_text_char(nibble_ascii(v[7:4]));
    put_text_char(nibble_ascii(v[3:0]));
  endfunction

  function automatic void put_record(input logic [7:0] count, input logic [15:0] addr,
                                     input logic [7:0] rec_type, input logic [7:0] dsum);
    logic [7:0] sum;
    sum = dsum + count + addr[15:8] + addr[7:0] + rec_type;
    put_text_char(CHAR_COLON);
    put_hex_byte(count);
    put_hex_byte(addr[15:8]);
    put_hex_byte(addr[7:0]);
    put_hex_byte(rec_type);
    for (int i = 0; i < int'(count) && i < NUM_RECORD_BYTES; i++) begin
      put_hex_byte(mdl_buf[i]);
    end
    put_hex_byte(8'h00 - sum);
    put_text_char(CHAR_EOL);
  endfunction

  function automatic void restart_record();
    mdl_count    = '0;
    mdl_sum      = '0;
    mdl_rec_addr = mdl_next;
  endfunction

  function automatic void load_start(input logic [15:0] v);
    mdl_start = v;
    if (mdl_count == 0) begin
      mdl_next     = v;
      mdl_rec_addr = v;
    end
  endfunction

  function automatic void encode_item(input logic op, input logic [7:0] data);
    int prev_size;
    prev_size = expected_text.size();
    if (op == OP_DATA) begin
      if (mdl_count < NUM_RECORD_BYTES) begin
        mdl_buf[mdl_count[3:0]] = data;
      end
      mdl_count = mdl_count + 5'd1;
      mdl_sum   = mdl_sum + data;
      mdl_next  = mdl_next + 16'd1;
      if (mdl_count >= NUM_RECORD_BYTES) begin
        put_record(8'(NUM_RECORD_BYTES), mdl_rec_addr, TYPE_DATA, mdl_sum);
        restart_record();
      end
    end else begin
      if (mdl_count != 0) begin
        put_record(8'(mdl_count), mdl_rec_addr, TYPE_DATA, mdl_sum);
      end
      put_record(END_COUNT, END_ADDRESS, TYPE_END, 8'h00);
      mdl_next = mdl_start;
      restart_record();
    end
    if (expected_text.size() > prev_size) begin
      expected_text[expected_text.size() - 1].last = 1'b1;
    end
  endfunction

  // Offer one request; return at the edge that accepts it.
  task automatic send_request(input logic op, input logic [7:0] data, input bit bare_end);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    encode_item(op, data);
    if (bare_end) begin
      repeat (END_RECORD_TEXT.len()) void'(expected_text.pop_back());
      for (int i = 0; i < END_RECORD_TEXT.len(); i++) begin
        expected_text.push_back('{ch: 7'(END_RECORD_TEXT[i]),
                                  last: (i == END_RECORD_TEXT.len() - 1)});
      end
    end
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    load_start(v);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    #10ms;
    $display("tb failed");
    $finish;
  end

  // Sink: hold once for a long stretch on request, else stall in segments.
  initial begin
    int seg_left;
    int seg_mode;
    seg_left = 0;
    seg_mode = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (seg_mode)
          0: begin
            m_tready <= 1'b1;
          end
          1: begin
            m_tready <= 1'($urandom_range(0, 1));
          end
          default: begin
            m_tready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  always @(negedge clk) begin
    text_char_t exp_c;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        err_count++;
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $realtime, m_tdata, m_tlast);
      end else begin
        exp_c = expected_text.pop_front();
        if (m_tdata !== {1'b0, exp_c.ch}) begin
          err_count++;
          $display("%0t: character mismatch: expected %h, actual %h",
                   $realtime, {1'b0, exp_c.ch}, m_tdata);
        end
        if (m_tlast !== exp_c.last) begin
          err_count++;
          $display("%0t: last mismatch: expected %b, actual %b",
                   $realtime, exp_c.last, m_tlast);
        end
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int phase_len;
    logic [15:0] start_val;
    clk        = 1'b0;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = OP_DATA;
    err_count  = 0;
    burst_left = 0;
    long_hold  = 1'b0;
    mdl_start  = START_ADDRESS_RST;
    mdl_count  = '0;
    mdl_next   = START_ADDRESS_RST;
    mdl_rec_addr = START_ADDRESS_RST;
    mdl_sum    = '0;
    for (int i = 0; i < NUM_RECORD_BYTES; i++) mdl_buf[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_request(DIR_TABLE[r].op, DIR_TABLE[r].data, DIR_TABLE[r].bare_end);
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if (phase < NUM_SWEEP || $urandom_range(0, 3) != 0) begin
        start_val = (phase < NUM_SWEEP) ? START_SWEEP[phase] : 16'($urandom_range(0, 16'hFFFF));
        write_start(start_val);
      end
      if (phase == 0) begin
        long_hold = 1'b1;
      end
      phase_len = $urandom_range(15, 60);
      for (int i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 23) == 0) begin
          send_request(OP_END, 8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_request(OP_DATA, 8'($urandom_range(0, 255)), 1'b0);
        end
        sent++;
      end
      phase++;
    end

    // Flush the final partial record and close the stream.
    send_request(OP_END, 8'h00, 1'b0);
    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
